[rtl/core/disk_write_pulse_demodulator_top_assert.svh]
// Assertion macros shared by the checker of the write pulse demodulator.
// Needs nothing else; every macro samples on i_clk and idles during reset.
`ifndef DISK_WRITE_PULSE_DEMODULATOR_TOP_ASSERT_SVH
`define DISK_WRITE_PULSE_DEMODULATOR_TOP_ASSERT_SVH

// same-cycle implication
`define DWPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dwpd: same-cycle check failed");

// next-cycle implication
`define DWPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dwpd: next-cycle check failed");

`endif

[rtl/core/dwpd_pkg.sv]
// Types and codes of the write pulse demodulator.
// Used by every module of the block; depends on nothing.
package dwpd_pkg;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_GAP  = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [1:0] FUNC_EDGE  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam logic [1:0] CFG_SHORT_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_MIDDLE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_GAP_SKIP      = 2'd2;
    localparam logic [1:0] CFG_RESTART_SHORT = 2'd3;

    localparam logic [15:0] RST_SHORT_LIMIT   = 16'd12;
    localparam logic [15:0] RST_MIDDLE_LIMIT  = 16'd17;
    localparam logic [15:0] RST_GAP_SKIP      = 16'd8;
    localparam logic [15:0] RST_RESTART_SHORT = 16'd64;

    typedef struct packed {
        logic [15:0] short_limit;
        logic [15:0] middle_limit;
        logic [15:0] gap_skip_edges;
        logic [15:0] restart_short_edges;
    } t_cfg;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]  func;
        logic        is_short;
        logic        is_middle;
        logic [15:0] block_bytes;
    } t_cmd;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       block_done;
        logic       restarted;
        logic       bad_pulse;
        logic [1:0] mode;
    } t_result;

    // decoder state plus the per-word result flags that bit packing raises
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] skip_count;
        logic        carrier;
        logic [7:0]  shift_byte;
        logic [2:0]  bit_count;
        logic [15:0] bytes_left;
        logic [15:0] block_length;
        logic [7:0]  byte_out;
        logic        byte_valid;
        logic        block_done;
    } t_work;

endpackage

[rtl/core/dwpd_front.sv]
// Front end: accepts words, forms the edge interval and classifies it.
// Depends on dwpd_pkg; feeds the command queue.
module dwpd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_func,
    input  logic [15:0]      i_capture,
    input  logic [15:0]      i_block_bytes,
    input  dwpd_pkg::t_cfg   i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output dwpd_pkg::t_cmd   o_cmd
);

    logic [15:0] r_last;
    logic [15:0] n_last;
    logic [15:0] interval;
    logic        is_short;

    // wraps modulo 2^16 with the free-running timer
    assign interval = i_capture - r_last;
    assign is_short = interval < i_cfg.short_limit;

    assign o_push = i_valid && !i_q_full;

    always_comb begin
        o_cmd.func        = i_func;
        o_cmd.is_short    = is_short;
        o_cmd.is_middle   = !is_short && (interval < i_cfg.middle_limit);
        o_cmd.block_bytes = i_block_bytes;
    end

    always_comb begin
        n_last = r_last;
        if (o_push && i_func == dwpd_pkg::FUNC_EDGE) begin
            n_last = i_capture;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 16'd0;
        end else begin
            r_last <= n_last;
        end
    end

endmodule

[rtl/core/dwpd_queue.sv]
// Two-word command queue between front and back end.
// Depends on dwpd_pkg for the command type.
module dwpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dwpd_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output dwpd_pkg::t_cmd  o_head
);

    dwpd_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_full     = r_count == 2'd2;
    assign o_nonempty = r_count != 2'd0;
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/dwpd_back.sv]
// Back end: gap, data and stopping sequencer, bit packing and result register.
// Depends on dwpd_pkg; takes commands from dwpd_queue.
module dwpd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nonempty,
    input  dwpd_pkg::t_cmd     i_cmd,
    input  dwpd_pkg::t_cfg     i_cfg,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output dwpd_pkg::t_result  o_result
);

    dwpd_pkg::t_work   r_st;
    dwpd_pkg::t_work   n_st;
    dwpd_pkg::t_result r_res;
    dwpd_pkg::t_result n_res;
    logic              r_valid;
    logic              n_valid;

    // shift one bit in LSB first; ignored once the block has ended
    function automatic dwpd_pkg::t_work push_bit(input dwpd_pkg::t_work s, input logic b);
        dwpd_pkg::t_work w;
        w = s;
        if (s.mode == dwpd_pkg::MODE_DATA) begin
            w.shift_byte = {b, s.shift_byte[7:1]};
            w.bit_count  = s.bit_count + 3'd1;
            if (w.bit_count == 3'd0) begin
                w.byte_out   = w.shift_byte;
                w.byte_valid = 1'b1;
                if (s.bytes_left <= 16'd1) begin
                    w.bytes_left = 16'd0;
                    w.block_done = 1'b1;
                    w.skip_count = 16'd0;
                    w.mode       = dwpd_pkg::MODE_STOP;
                end else begin
                    w.bytes_left = s.bytes_left - 16'd1;
                end
            end
        end
        return w;
    endfunction

    assign o_pop    = i_q_nonempty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    always_comb begin
        dwpd_pkg::t_work w;
        logic            restarted;
        logic            bad;
        w            = r_st;
        w.byte_out   = 8'd0;
        w.byte_valid = 1'b0;
        w.block_done = 1'b0;
        restarted    = 1'b0;
        bad          = 1'b0;
        case (i_cmd.func)
            dwpd_pkg::FUNC_START: begin
                w.mode         = dwpd_pkg::MODE_GAP;
                w.skip_count   = 16'd0;
                w.bytes_left   = i_cmd.block_bytes;
                w.block_length = i_cmd.block_bytes;
            end
            dwpd_pkg::FUNC_STOP: begin
                w.mode = dwpd_pkg::MODE_IDLE;
            end
            dwpd_pkg::FUNC_EDGE: begin
                case (r_st.mode)
                    dwpd_pkg::MODE_STOP: begin
                        if (i_cmd.is_short) begin
                            if (w.skip_count != 16'hFFFF) begin
                                w.skip_count = w.skip_count + 16'd1;
                            end
                        end else begin
                            w.skip_count = 16'd0;
                        end
                        if (w.skip_count >= i_cfg.restart_short_edges) begin
                            w.mode       = dwpd_pkg::MODE_GAP;
                            w.skip_count = 16'd0;
                            w.bytes_left = w.block_length;
                            restarted    = 1'b1;
                        end
                    end
                    dwpd_pkg::MODE_GAP: begin
                        if (w.skip_count < i_cfg.gap_skip_edges) begin
                            w.skip_count = w.skip_count + 16'd1;
                        end else if (!i_cmd.is_short) begin
                            w.carrier    = 1'b0;
                            w.bit_count  = 3'd0;
                            w.shift_byte = 8'd0;
                            w.mode       = dwpd_pkg::MODE_DATA;
                        end
                    end
                    dwpd_pkg::MODE_DATA: begin
                        if (r_st.carrier) begin
                            if (i_cmd.is_short) begin
                                w = push_bit(w, 1'b0);
                            end else if (i_cmd.is_middle) begin
                                w         = push_bit(w, 1'b1);
                                w.carrier = 1'b0;
                            end else begin
                                bad = 1'b1;
                            end
                        end else begin
                            if (i_cmd.is_short) begin
                                w = push_bit(w, 1'b1);
                            end else if (i_cmd.is_middle) begin
                                w         = push_bit(w, 1'b0);
                                w         = push_bit(w, 1'b0);
                                w.carrier = 1'b1;
                            end else begin
                                w = push_bit(w, 1'b0);
                                w = push_bit(w, 1'b1);
                            end
                        end
                    end
                    default: begin
                        // idle: only the front end's stamp moves
                    end
                endcase
            end
            default: begin
                // unknown function leaves the state alone
            end
        endcase
        n_st             = w;
        n_res.byte_out   = w.byte_out;
        n_res.byte_valid = w.byte_valid;
        n_res.block_done = w.block_done;
        n_res.restarted  = restarted;
        n_res.bad_pulse  = bad;
        n_res.mode       = w.mode;
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_st <= n_st;
            end
            r_valid <= n_valid;
        end
    end

endmodule

[rtl/core/disk_write_pulse_demodulator_top.sv]
// Top level of the write pulse demodulator: configuration registers and glue.
// Depends on dwpd_pkg, dwpd_front, dwpd_queue and dwpd_back.
//
// Input channel (i_valid / o_stall): one word per command. i_func selects an
// edge capture (i_capture is the timer stamp), a block start (i_block_bytes is
// the byte count) or a stop to idle.
// Output channel (o_valid / i_stall): exactly one result word per input word,
// in order: a completed byte with its flags and the mode after the command.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; index 0
// short limit, 1 middle limit, 2 gap skip edges, 3 restart short edges.
// An accepted input word is written into the queue and then moved by the back
// end into the output register, from which the receiver takes it.
// Throughput: one word per cycle unless the receiver stalls; the front end
// classifies an edge in the accept cycle, the back end updates the decoder
// state and output register in the same cycle, and a two-word queue parts them.
// When the receiver stalls, the result register holds, the queue fills and
// o_stall rises once both queue entries are taken.
// Synchronous reset clears the queue, the output valid flag, the decoder state
// (idle mode) and loads the default limits.
module disk_write_pulse_demodulator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_capture,
    input  logic [15:0] i_block_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_out,
    output logic        o_byte_valid,
    output logic        o_block_done,
    output logic        o_restarted,
    output logic        o_bad_pulse,
    output logic [1:0]  o_mode,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    dwpd_pkg::t_cfg    r_cfg;
    dwpd_pkg::t_cmd    front_cmd;
    dwpd_pkg::t_cmd    head_cmd;
    dwpd_pkg::t_result result;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_nonempty;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_limit         <= dwpd_pkg::RST_SHORT_LIMIT;
            r_cfg.middle_limit        <= dwpd_pkg::RST_MIDDLE_LIMIT;
            r_cfg.gap_skip_edges      <= dwpd_pkg::RST_GAP_SKIP;
            r_cfg.restart_short_edges <= dwpd_pkg::RST_RESTART_SHORT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dwpd_pkg::CFG_SHORT_LIMIT:   r_cfg.short_limit         <= i_cfg_data;
                dwpd_pkg::CFG_MIDDLE_LIMIT:  r_cfg.middle_limit        <= i_cfg_data;
                dwpd_pkg::CFG_GAP_SKIP:      r_cfg.gap_skip_edges      <= i_cfg_data;
                dwpd_pkg::CFG_RESTART_SHORT: r_cfg.restart_short_edges <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dwpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_func        (i_func),
        .i_capture     (i_capture),
        .i_block_bytes (i_block_bytes),
        .i_cfg         (r_cfg),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    dwpd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (front_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head_cmd)
    );

    dwpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_cmd        (head_cmd),
        .i_cfg        (r_cfg),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_result     (result)
    );

    assign o_byte_out   = result.byte_out;
    assign o_byte_valid = result.byte_valid;
    assign o_block_done = result.block_done;
    assign o_restarted  = result.restarted;
    assign o_bad_pulse  = result.bad_pulse;
    assign o_mode       = result.mode;

endmodule

[rtl/core/dwpd_checker.sv]
// Port-level checks of the write pulse demodulator, bound to the top level.
// Depends on dwpd_pkg and disk_write_pulse_demodulator_top_assert.svh.
`include "disk_write_pulse_demodulator_top_assert.svh"

module dwpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_byte_out,
    input logic        o_byte_valid,
    input logic        o_block_done,
    input logic        o_restarted,
    input logic        o_bad_pulse,
    input logic [1:0]  o_mode
);

    // a held result stays offered
    `DWPD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    // the end of a block comes with its last byte and enters stopping
    `DWPD_ASSERT_NOW(a_done_mode, o_valid && o_block_done,
        o_byte_valid && o_mode == dwpd_pkg::MODE_STOP)
    // a restart always lands in the gap
    `DWPD_ASSERT_NOW(a_restart_gap, o_valid && o_restarted,
        o_mode == dwpd_pkg::MODE_GAP && !o_byte_valid && !o_bad_pulse)
    // a bad pulse produces no bits and leaves data mode standing
    `DWPD_ASSERT_NOW(a_bad_data, o_valid && o_bad_pulse,
        o_mode == dwpd_pkg::MODE_DATA && !o_byte_valid && o_byte_out == 8'd0)

endmodule

bind disk_write_pulse_demodulator_top dwpd_checker u_dwpd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_byte_out   (o_byte_out),
    .o_byte_valid (o_byte_valid),
    .o_block_done (o_block_done),
    .o_restarted  (o_restarted),
    .o_bad_pulse  (o_bad_pulse),
    .o_mode       (o_mode)
);

[dv/disk_write_pulse_demodulator_top_tb.sv]
// Self-checking testbench of the write pulse demodulator top level.
// Needs dwpd_pkg and the RTL of disk_write_pulse_demodulator_top; a scoreboard
// class predicts every result word and checks it in order.

class demod_scoreboard;
    logic [15:0] short_lim;
    logic [15:0] middle_lim;
    logic [15:0] gap_skip;
    logic [15:0] restart_short;

    logic [1:0]  mode_q;
    logic [15:0] last_cap;
    logic [15:0] edge_count;
    logic        carrier;
    logic [7:0]  shift_q;
    logic [2:0]  bit_cnt;
    logic [15:0] bytes_left;
    logic [15:0] block_len;

    dwpd_pkg::t_result expected_words[$];
    dwpd_pkg::t_result cur;
    int                errors;

    function new();
        short_lim     = dwpd_pkg::RST_SHORT_LIMIT;
        middle_lim    = dwpd_pkg::RST_MIDDLE_LIMIT;
        gap_skip      = dwpd_pkg::RST_GAP_SKIP;
        restart_short = dwpd_pkg::RST_RESTART_SHORT;
        mode_q        = dwpd_pkg::MODE_IDLE;
        last_cap      = '0;
        edge_count    = '0;
        carrier       = 1'b0;
        shift_q       = '0;
        bit_cnt       = '0;
        bytes_left    = '0;
        block_len     = '0;
        errors        = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [15:0] value);
        case (index)
            dwpd_pkg::CFG_SHORT_LIMIT:   short_lim = value;
            dwpd_pkg::CFG_MIDDLE_LIMIT:  middle_lim = value;
            dwpd_pkg::CFG_GAP_SKIP:      gap_skip = value;
            dwpd_pkg::CFG_RESTART_SHORT: restart_short = value;
            default: ;
        endcase
    endfunction

    // shift one bit in, LSB first; drop it once the block has ended
    function void shift_in(logic b);
        if (mode_q != dwpd_pkg::MODE_DATA)
            return;
        shift_q = {b, shift_q[7:1]};
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt == 3'd0) begin
            cur.byte_out   = shift_q;
            cur.byte_valid = 1'b1;
            if (bytes_left <= 16'd1) begin
                bytes_left     = '0;
                cur.block_done = 1'b1;
                edge_count     = '0;
                mode_q         = dwpd_pkg::MODE_STOP;
            end else begin
                bytes_left = bytes_left - 16'd1;
            end
        end
    endfunction

    function void note_word(logic [1:0] func, logic [15:0] cap, logic [15:0] blen);
        logic [15:0] interval;
        logic        is_short;
        logic        is_middle;
        cur = '0;
        case (func)
            dwpd_pkg::FUNC_START: begin
                mode_q     = dwpd_pkg::MODE_GAP;
                edge_count = '0;
                bytes_left = blen;
                block_len  = blen;
            end
            dwpd_pkg::FUNC_STOP: mode_q = dwpd_pkg::MODE_IDLE;
            dwpd_pkg::FUNC_EDGE: begin
                interval  = cap - last_cap;
                is_short  = interval < short_lim;
                is_middle = !is_short && interval < middle_lim;
                last_cap  = cap;
                case (mode_q)
                    dwpd_pkg::MODE_STOP: begin
                        if (is_short) begin
                            if (edge_count != 16'hFFFF)
                                edge_count = edge_count + 16'd1;
                        end else begin
                            edge_count = '0;
                        end
                        if (edge_count >= restart_short) begin
                            mode_q        = dwpd_pkg::MODE_GAP;
                            edge_count    = '0;
                            bytes_left    = block_len;
                            cur.restarted = 1'b1;
                        end
                    end
                    dwpd_pkg::MODE_GAP: begin
                        if (edge_count < gap_skip) begin
                            edge_count = edge_count + 16'd1;
                        end else if (!is_short) begin
                            carrier = 1'b0;
                            bit_cnt = '0;
                            shift_q = '0;
                            mode_q  = dwpd_pkg::MODE_DATA;
                        end
                    end
                    dwpd_pkg::MODE_DATA: begin
                        if (carrier) begin
                            if (is_short) begin
                                shift_in(1'b0);
                            end else if (is_middle) begin
                                shift_in(1'b1);
                                carrier = 1'b0;
                            end else begin
                                cur.bad_pulse = 1'b1;
                            end
                        end else begin
                            if (is_short) begin
                                shift_in(1'b1);
                            end else if (is_middle) begin
                                shift_in(1'b0);
                                shift_in(1'b0);
                                carrier = 1'b1;
                            end else begin
                                shift_in(1'b0);
                                shift_in(1'b1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        cur.mode = mode_q;
        expected_words.push_back(cur);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch on %s: got %0h, want %0h", what, got, want);
    endtask

    task check_word(dwpd_pkg::t_result got);
        dwpd_pkg::t_result want;
        if (expected_words.size() == 0) begin
            report("unexpected word", 16'(got), 16'h0);
            return;
        end
        want = expected_words.pop_front();
        if (got.byte_out !== want.byte_out)
            report("byte_out", 16'(got.byte_out), 16'(want.byte_out));
        if (got.byte_valid !== want.byte_valid)
            report("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
        if (got.block_done !== want.block_done)
            report("block_done", 16'(got.block_done), 16'(want.block_done));
        if (got.restarted !== want.restarted)
            report("restarted", 16'(got.restarted), 16'(want.restarted));
        if (got.bad_pulse !== want.bad_pulse)
            report("bad_pulse", 16'(got.bad_pulse), 16'(want.bad_pulse));
        if (got.mode !== want.mode)
            report("mode", 16'(got.mode), 16'(want.mode));
    endtask
endclass

module disk_write_pulse_demodulator_top_tb;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int NUM_PHASES      = 12;
    localparam int QUIET_LIMIT     = 2000;

    typedef enum logic [1:0] {IV_SHORT, IV_MIDDLE, IV_LONG} t_interval;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = '0;
    logic [15:0] i_capture = '0;
    logic [15:0] i_block_bytes = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_byte_out;
    logic        o_byte_valid;
    logic        o_block_done;
    logic        o_restarted;
    logic        o_bad_pulse;
    logic [1:0]  o_mode;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    demod_scoreboard sb;

    logic [15:0] cfg_short   = dwpd_pkg::RST_SHORT_LIMIT;
    logic [15:0] cfg_middle  = dwpd_pkg::RST_MIDDLE_LIMIT;
    logic [15:0] cfg_gap     = dwpd_pkg::RST_GAP_SKIP;
    logic [15:0] cfg_restart = dwpd_pkg::RST_RESTART_SHORT;
    logic [15:0] stamp = '0;
    bit          idle_on = 1'b1;
    int          sent = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    int          rnd_short;

    disk_write_pulse_demodulator_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_capture    (i_capture),
        .i_block_bytes(i_block_bytes),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_byte_out   (o_byte_out),
        .o_byte_valid (o_byte_valid),
        .o_block_done (o_block_done),
        .o_restarted  (o_restarted),
        .o_bad_pulse  (o_bad_pulse),
        .o_mode       (o_mode),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall = 1'b1;
            stall_left = $urandom_range(0, 8);
        end else begin
            i_stall = 1'b0;
        end
    end

    // sample all three channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_word('{byte_out: o_byte_out, byte_valid: o_byte_valid,
                                block_done: o_block_done, restarted: o_restarted,
                                bad_pulse: o_bad_pulse, mode: o_mode});
            if (i_valid && !o_stall)
                sb.note_word(i_func, i_capture, i_block_bytes);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_register(i_cfg_index, i_cfg_data);
            if ((o_valid && !i_stall) || (i_valid && !o_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    function automatic logic [15:0] pick_delta(t_interval cls);
        int lo;
        lo = (cfg_middle > cfg_short) ? int'(cfg_middle) : int'(cfg_short);
        if (cls == IV_SHORT)
            return 16'($urandom_range(int'(cfg_short) - 1, 0));
        if (cls == IV_MIDDLE && cfg_middle > cfg_short)
            return 16'($urandom_range(int'(cfg_middle) - 1, int'(cfg_short)));
        // keep most long intervals near the limit
        if (lo < 65000 && $urandom_range(0, 3) != 0)
            return 16'($urandom_range(lo + 12, lo));
        return 16'($urandom_range(65535, lo));
    endfunction

    function automatic t_interval random_class();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return IV_SHORT;
        if (r < 75)
            return IV_MIDDLE;
        return IV_LONG;
    endfunction

    // call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(logic [1:0] func, logic [15:0] cap, logic [15:0] blen);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_func        = func;
        i_capture     = cap;
        i_block_bytes = blen;
        if (func == dwpd_pkg::FUNC_EDGE)
            stamp = cap;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_edge(t_interval cls);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + pick_delta(cls), 16'($urandom));
    endtask

    // one block: start, gap edges, gap end, data edges, short run for restart, sometimes a stop
    task automatic send_block();
        int blen;
        int n;
        int runs;
        case ($urandom_range(0, 15))
            0: blen = 0;
            1: blen = $urandom_range(1, 65535);
            default: blen = $urandom_range(1, 3);
        endcase
        send_word(dwpd_pkg::FUNC_START, 16'($urandom), 16'(blen));
        n = (cfg_gap <= 16) ? int'(cfg_gap) : 6;
        repeat (n) send_edge(random_class());
        repeat ($urandom_range(0, 3)) send_edge(IV_SHORT);
        send_edge($urandom_range(0, 1) ? IV_MIDDLE : IV_LONG);
        n = (blen == 0) ? 1 : ((blen > 3) ? 3 : blen);
        repeat ($urandom_range(2, 14 * n + 4)) send_edge(random_class());
        runs = (cfg_restart <= 32) ? int'(cfg_restart) + $urandom_range(0, 2) : 10;
        for (int k = 0; k < runs; k++)
            send_edge(($urandom_range(0, 15) == 0) ? IV_LONG : IV_SHORT);
        if ($urandom_range(0, 3) == 0)
            send_word(dwpd_pkg::FUNC_STOP, 16'($urandom), 16'($urandom));
    endtask

    task automatic write_register(logic [1:0] index, logic [15:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        case (index)
            dwpd_pkg::CFG_SHORT_LIMIT:   cfg_short = value;
            dwpd_pkg::CFG_MIDDLE_LIMIT:  cfg_middle = value;
            dwpd_pkg::CFG_GAP_SKIP:      cfg_gap = value;
            dwpd_pkg::CFG_RESTART_SHORT: cfg_restart = value;
            default: ;
        endcase
    endtask

    // hold the sender until every result word is back, then reprogram
    task automatic configure(logic [15:0] s, logic [15:0] m, logic [15:0] g, logic [15:0] r);
        i_valid = 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        write_register(dwpd_pkg::CFG_SHORT_LIMIT, s);
        write_register(dwpd_pkg::CFG_MIDDLE_LIMIT, m);
        write_register(dwpd_pkg::CFG_GAP_SKIP, g);
        write_register(dwpd_pkg::CFG_RESTART_SHORT, r);
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle edges with timer wrap, unknown function, stop and start with defaults
        send_word(dwpd_pkg::FUNC_EDGE, 16'hFFFF, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, 16'h0000, 16'hFFFF);
        send_word(FUNC_NONE, 16'hFFFF, 16'hFFFF);
        send_word(dwpd_pkg::FUNC_STOP, 16'h0000, 16'h0000);
        send_word(dwpd_pkg::FUNC_START, 16'hFFFF, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, 16'd4, 16'h0000);

        // zero-length block through every decode table entry
        configure(dwpd_pkg::RST_SHORT_LIMIT, dwpd_pkg::RST_MIDDLE_LIMIT, 16'd0, 16'd1);
        send_word(dwpd_pkg::FUNC_START, 16'h0000, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd20, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd20, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd14, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd30, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd3, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd15, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd5, 16'h0000);
        // byte completes on the first bit; the second bit of this edge is dropped
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd40, 16'h0000);
        send_word(dwpd_pkg::FUNC_EDGE, stamp + 16'd2, 16'h0000);
        send_word(dwpd_pkg::FUNC_STOP, 16'h0000, 16'h0000);
        send_word(dwpd_pkg::FUNC_START, 16'h0000, 16'hFFFF);
        send_word(dwpd_pkg::FUNC_EDGE, stamp, 16'h0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p >= NUM_PHASES - 2)
                idle_on = 1'b0;
            case (p)
                0: configure(dwpd_pkg::RST_SHORT_LIMIT, dwpd_pkg::RST_MIDDLE_LIMIT,
                             dwpd_pkg::RST_GAP_SKIP, dwpd_pkg::RST_RESTART_SHORT);
                1: configure(16'd1, 16'hFFFF, 16'd0, 16'd1);
                2: configure(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
                3: configure(16'd10, 16'd1, 16'd2, 16'd3);
                default: begin
                    rnd_short = $urandom_range(2, 40);
                    configure(16'(rnd_short), 16'(rnd_short + $urandom_range(0, 30)),
                              16'($urandom_range(0, 12)), 16'($urandom_range(1, 24)));
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 5) == 0)
                    send_word(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
                else
                    send_block();
            end
        end

        i_valid = 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
